// ===== rtl/core/tpcr_pkg.sv =====
// Shared types for the Thumb PC-relative relocator.
// Holds the instruction class codes and the descriptor that the front end hands to the back end.
// No dependencies.
package tpcr_pkg;

    typedef enum logic [4:0] {
        CLS_COPY      = 5'd0,
        CLS_BCOND16   = 5'd1,
        CLS_B16       = 5'd2,
        CLS_BX_PC     = 5'd3,
        CLS_ADD_PC    = 5'd4,
        CLS_MOV_PC    = 5'd5,
        CLS_ADR16     = 5'd6,
        CLS_LDR_LIT16 = 5'd7,
        CLS_BLX       = 5'd8,
        CLS_BL        = 5'd9,
        CLS_BCOND32   = 5'd10,
        CLS_B32       = 5'd11,
        CLS_ADR32_ADD = 5'd12,
        CLS_ADR32_SUB = 5'd13,
        CLS_LDR_LIT32 = 5'd14,
        CLS_TBB       = 5'd15,
        CLS_TBH       = 5'd16
    } t_tpcr_class;

    typedef struct packed {
        t_tpcr_class cls;
        logic        wide;
        logic [15:0] first_half;
        logic [15:0] second_half;
        logic [31:0] value;
    } t_tpcr_desc;

    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/core/tpcr_front.sv =====
// Front end of the relocator: classifies one instruction and computes its absolute value.
// Depends on tpcr_pkg for the class codes and the descriptor type.
module tpcr_front
    import tpcr_pkg::*;
(
    input  logic [31:0] i_fetch_pc,
    input  logic [15:0] i_first_half,
    input  logic [15:0] i_second_half,
    input  logic [31:0] i_literal_word,
    output t_tpcr_desc  o_desc
);

    logic [15:0] h1;
    logic [15:0] h2;
    logic [31:0] word;
    logic        wide;
    t_tpcr_class cls16;
    t_tpcr_class cls32;
    t_tpcr_class cls;
    logic        s_bit;
    logic        j1;
    logic        j2;
    logic        i1;
    logic        i2;
    logic [11:0] imm12;
    logic [31:0] base;
    logic [31:0] offset;
    logic        subtract;
    logic        use_lit;
    logic        thumb;
    logic [31:0] sum;

    assign h1   = i_first_half;
    assign h2   = i_second_half;
    assign word = {h1, h2};
    assign wide = (h1[15:11] >= 5'h1D);

    assign s_bit = h1[10];
    assign j1    = h2[13];
    assign j2    = h2[11];
    assign i1    = ~(j1 ^ s_bit);
    assign i2    = ~(j2 ^ s_bit);
    assign imm12 = {h1[10], h2[14:12], h2[7:0]};

    always_comb begin
        priority if ((h1 & 16'hF000) == 16'hD000) cls16 = CLS_BCOND16;
        else if ((h1 & 16'hF800) == 16'hE000)     cls16 = CLS_B16;
        else if ((h1 & 16'hFFF8) == 16'h4778)     cls16 = CLS_BX_PC;
        else if ((h1 & 16'hFF78) == 16'h4478)     cls16 = CLS_ADD_PC;
        else if ((h1 & 16'hFF78) == 16'h4678)     cls16 = CLS_MOV_PC;
        else if ((h1 & 16'hF800) == 16'hA000)     cls16 = CLS_ADR16;
        else if ((h1 & 16'hF800) == 16'h4800)     cls16 = CLS_LDR_LIT16;
        else                                      cls16 = CLS_COPY;
    end

    always_comb begin
        priority if ((word & 32'hF800D000) == 32'hF000C000) cls32 = CLS_BLX;
        else if ((word & 32'hF800D000) == 32'hF000D000)     cls32 = CLS_BL;
        else if ((word & 32'hF800D000) == 32'hF0008000)     cls32 = CLS_BCOND32;
        else if ((word & 32'hF800D000) == 32'hF0009000)     cls32 = CLS_B32;
        else if ((word & 32'hFBFF8000) == 32'hF2AF0000)     cls32 = CLS_ADR32_ADD;
        else if ((word & 32'hFBFF8000) == 32'hF20F0000)     cls32 = CLS_ADR32_SUB;
        else if ((word & 32'hFF7F0000) == 32'hF85F0000)     cls32 = CLS_LDR_LIT32;
        else if ((word & 32'hFFFF00F0) == 32'hE8DF0000)     cls32 = CLS_TBB;
        else if ((word & 32'hFFFF00F0) == 32'hE8DF0010)     cls32 = CLS_TBH;
        else                                                cls32 = CLS_COPY;
    end

    assign cls = wide ? cls32 : cls16;

    // Pick base and offset for the single shared adder
    always_comb begin
        base     = i_fetch_pc;
        offset   = 32'd0;
        subtract = 1'b0;
        use_lit  = 1'b0;
        thumb    = 1'b0;
        unique case (cls)
            CLS_BCOND16: begin
                offset = {{23{h1[7]}}, h1[7:0], 1'b0};
                thumb  = 1'b1;
            end
            CLS_B16: begin
                offset = {{20{h1[10]}}, h1[10:0], 1'b0};
                thumb  = 1'b1;
            end
            CLS_BX_PC: begin
                thumb = 1'b1;
            end
            CLS_ADR16: begin
                base   = {i_fetch_pc[31:2], 2'b00};
                offset = {22'd0, h1[7:0], 2'b00};
            end
            CLS_LDR_LIT16, CLS_LDR_LIT32: begin
                use_lit = 1'b1;
            end
            CLS_BLX: begin
                offset = {{7{s_bit}}, s_bit, i1, i2, h1[9:0], h2[10:1], 2'b00};
            end
            CLS_BL, CLS_B32: begin
                offset = {{7{s_bit}}, s_bit, i1, i2, h1[9:0], h2[10:0], 1'b0};
                thumb  = 1'b1;
            end
            CLS_BCOND32: begin
                offset = {{11{s_bit}}, s_bit, j2, j1, h1[5:0], h2[10:0], 1'b0};
                thumb  = 1'b1;
            end
            CLS_ADR32_ADD: begin
                base   = {i_fetch_pc[31:2], 2'b00};
                offset = {20'd0, imm12};
            end
            CLS_ADR32_SUB: begin
                base     = {i_fetch_pc[31:2], 2'b00};
                offset   = {20'd0, imm12};
                subtract = 1'b1;
            end
            CLS_COPY, CLS_ADD_PC, CLS_MOV_PC, CLS_TBB, CLS_TBH: begin
                offset = 32'd0;
            end
            default: begin
                offset = 32'd0;
            end
        endcase
    end

    // Subtract as add of the complement with carry in
    assign sum = base + (subtract ? ~offset : offset) + {31'd0, subtract};

    always_comb begin
        o_desc.cls         = cls;
        o_desc.wide        = wide;
        o_desc.first_half  = h1;
        o_desc.second_half = h2;
        o_desc.value       = use_lit ? i_literal_word : (sum | {31'd0, thumb});
    end

endmodule

// ===== rtl/core/tpcr_queue.sv =====
// Short descriptor queue between front end and back end.
// Depends on tpcr_pkg for the descriptor type and queue depth.
module tpcr_queue
    import tpcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_tpcr_desc i_push_desc,
    input  logic       i_pop,
    output t_tpcr_desc o_head,
    output logic       o_empty,
    output logic       o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_tpcr_desc         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

// ===== rtl/core/tpcr_back.sv =====
// Back end of the relocator: walks one descriptor and emits its replacement halfwords.
// Depends on tpcr_pkg for the class codes and the descriptor type.
module tpcr_back
    import tpcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tpcr_desc  i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_strobe,
    output logic [15:0] o_out_half,
    output logic        o_last_of_run,
    output logic [1:0]  o_consumed_halves,
    output logic [4:0]  o_class_code
);

    localparam logic [15:0] HW_NOP       = 16'hBF00;
    localparam logic [15:0] HW_LDRW_PC   = 16'hF8DF;
    localparam logic [15:0] HW_LDRW_PC2  = 16'hF000;
    localparam logic [15:0] HW_SKIP3     = 16'hE003;
    localparam logic [15:0] HW_SKIP2     = 16'hE002;
    localparam logic [15:0] HW_SKIP1     = 16'hE001;
    localparam logic [15:0] HW_ADR_LR    = 16'hF20F;
    localparam logic [15:0] HW_ADR_LR2   = 16'h0E09;

    t_tpcr_desc  r_desc;
    logic        r_active;
    logic [3:0]  r_idx;
    logic        r_out_valid;
    logic [15:0] r_out_half;
    logic        r_out_last;
    logic [1:0]  r_out_cons;
    logic [4:0]  r_out_cls;

    logic        n_active;
    logic [3:0]  n_idx;

    logic [15:0] h1;
    logic [15:0] h2;
    logic [15:0] vlo;
    logic [15:0] vhi;
    logic [3:0]  run_len;
    logic        last_now;
    logic [15:0] hw;
    logic [2:0]  r_add;
    logic [7:0]  oh_add;
    logic [3:0]  r_lit;
    logic [3:0]  rm;
    logic [2:0]  r_tb;
    logic [2:0]  rx;
    logic [7:0]  oh_rx;

    assign h1  = r_desc.first_half;
    assign h2  = r_desc.second_half;
    assign vlo = r_desc.value[15:0];
    assign vhi = r_desc.value[31:16];

    // Scratch register choice for ADD Rdn,PC
    assign r_add  = ({h1[7], h1[2:0]} == 4'd7) ? 3'd6 : 3'd7;
    assign oh_add = 8'd1 << r_add;

    // Scratch registers for the table branch sequence
    assign rm    = h2[3:0];
    assign r_tb  = (rm == 4'd7) ? 3'd6 : 3'd7;
    assign rx    = (rm == 4'd7 || rm == 4'd6) ? 3'd5 : 3'd6;
    assign oh_rx = 8'd1 << rx;

    always_comb begin
        unique case (r_desc.cls)
            CLS_MOV_PC:                   r_lit = {1'b0, h1[2:0]};
            CLS_ADR16, CLS_LDR_LIT16:     r_lit = {1'b0, h1[10:8]};
            CLS_ADR32_ADD, CLS_ADR32_SUB: r_lit = h2[11:8];
            CLS_LDR_LIT32:                r_lit = h2[15:12];
            default:                      r_lit = 4'd0;
        endcase
    end

    always_comb begin
        unique case (r_desc.cls)
            CLS_COPY:                                   run_len = 4'd2;
            CLS_BCOND16, CLS_BLX, CLS_BL, CLS_BCOND32:  run_len = 4'd6;
            CLS_ADD_PC:                                 run_len = 4'd8;
            CLS_TBB, CLS_TBH:                           run_len = 4'd14;
            default:                                    run_len = 4'd4;
        endcase
    end

    assign last_now = (r_idx == run_len - 4'd1);

    always_comb begin
        hw = HW_NOP;
        unique case (r_desc.cls)
            CLS_COPY: begin
                if (r_idx == 4'd0) begin
                    hw = h1;
                end else begin
                    hw = r_desc.wide ? h2 : HW_NOP;
                end
            end
            CLS_BCOND16, CLS_BCOND32, CLS_BLX, CLS_BL: begin
                case (r_idx)
                    4'd0: begin
                        if (r_desc.cls == CLS_BCOND16) begin
                            hw = h1 & 16'hFF00;
                        end else if (r_desc.cls == CLS_BCOND32) begin
                            hw = {4'hD, h1[9:6], 8'h00};
                        end else begin
                            hw = HW_ADR_LR;
                        end
                    end
                    4'd1:    hw = (r_desc.cls == CLS_BLX || r_desc.cls == CLS_BL)
                                  ? HW_ADR_LR2 : HW_SKIP3;
                    4'd2:    hw = HW_LDRW_PC;
                    4'd3:    hw = HW_LDRW_PC2;
                    4'd4:    hw = vlo;
                    default: hw = vhi;
                endcase
            end
            CLS_B16, CLS_BX_PC, CLS_B32: begin
                case (r_idx)
                    4'd0:    hw = HW_LDRW_PC;
                    4'd1:    hw = HW_LDRW_PC2;
                    4'd2:    hw = vlo;
                    default: hw = vhi;
                endcase
            end
            CLS_ADD_PC: begin
                case (r_idx)
                    4'd0:    hw = {8'hB4, oh_add};
                    4'd1:    hw = {5'b01001, r_add, 8'h02};
                    4'd2:    hw = (h1 & 16'hFF87) | {10'd0, r_add, 3'd0};
                    4'd3:    hw = {8'hBC, oh_add};
                    4'd4:    hw = HW_SKIP2;
                    4'd5:    hw = HW_NOP;
                    4'd6:    hw = vlo;
                    default: hw = vhi;
                endcase
            end
            CLS_MOV_PC, CLS_ADR16, CLS_LDR_LIT16,
            CLS_ADR32_ADD, CLS_ADR32_SUB, CLS_LDR_LIT32: begin
                case (r_idx)
                    4'd0:    hw = {4'h4, 4'h8 | r_lit, 8'h00};
                    4'd1:    hw = HW_SKIP1;
                    4'd2:    hw = vlo;
                    default: hw = vhi;
                endcase
            end
            CLS_TBB, CLS_TBH: begin
                case (r_idx)
                    4'd0:    hw = {8'hB4, oh_rx};
                    4'd1:    hw = {5'b01001, r_tb, 8'h05};
                    4'd2:    hw = {8'h46, 1'b0, rm, rx};
                    4'd3:    hw = 16'hEB00 | {13'd0, r_tb};
                    4'd4:    hw = ((r_desc.cls == CLS_TBH) ? 16'h0040 : 16'h0000)
                                  | {5'd0, rx, 8'd0} | {13'd0, rx};
                    4'd5:    hw = ((r_desc.cls == CLS_TBH) ? 16'h8800 : 16'h7800)
                                  | {10'd0, rx, 3'd0} | {13'd0, rx};
                    4'd6:    hw = 16'hEB00 | {13'd0, r_tb};
                    4'd7:    hw = 16'h0040 | {5'd0, r_tb, 8'd0} | {13'd0, rx};
                    4'd8:    hw = 16'h3001 | {5'd0, r_tb, 8'd0};
                    4'd9:    hw = {8'hBC, oh_rx};
                    4'd10:   hw = 16'h4700 | {10'd0, r_tb, 3'd0};
                    4'd11:   hw = HW_NOP;
                    4'd12:   hw = vlo;
                    default: hw = vhi;
                endcase
            end
            default: begin
                hw = HW_NOP;
            end
        endcase
    end

    // Load the next descriptor on the last halfword so runs follow without a gap
    assign o_pop = !i_empty && (!r_active || last_now);

    always_comb begin
        n_active = r_active;
        n_idx    = r_idx;
        if (o_pop) begin
            n_active = 1'b1;
            n_idx    = 4'd0;
        end else if (r_active && last_now) begin
            n_active = 1'b0;
        end else if (r_active) begin
            n_idx = r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_idx       <= n_idx;
            r_out_valid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_head;
        end
        r_out_half <= hw;
        r_out_last <= last_now;
        r_out_cons <= r_desc.wide ? 2'd2 : 2'd1;
        r_out_cls  <= r_desc.cls;
    end

    assign o_strobe          = r_out_valid;
    assign o_out_half        = r_out_half;
    assign o_last_of_run     = r_out_last;
    assign o_consumed_halves = r_out_cons;
    assign o_class_code      = r_out_cls;

endmodule

// ===== rtl/core/thumb_pc_relative_relocator.sv =====
// An accepted transaction passes the descriptor queue, the back-end descriptor register and the output
// register before its first halfword is strobed. Throughput: one halfword per cycle while a transaction
// is being emitted; a transaction emits 2 to 14 halfwords (14 for TBB/TBH), set by its class.
// A 2-entry descriptor queue lets start be taken every cycle until it fills; busy marks full.
// Synchronous active-low reset empties the queue and idles the emitter; results cannot be stalled.
// Top level: ties the classifying front end, descriptor queue and emitting back end.
module thumb_pc_relative_relocator
    import tpcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_fetch_pc,
    input  logic [15:0] i_first_half,
    input  logic [15:0] i_second_half,
    input  logic [31:0] i_literal_word,
    output logic        o_strobe,
    output logic [15:0] o_out_half,
    output logic        o_last_of_run,
    output logic [1:0]  o_consumed_halves,
    output logic [4:0]  o_class_code
);

    t_tpcr_desc front_desc;
    t_tpcr_desc head_desc;
    logic       q_empty;
    logic       q_full;
    logic       q_pop;

    tpcr_front u_front (
        .i_fetch_pc     (i_fetch_pc),
        .i_first_half   (i_first_half),
        .i_second_half  (i_second_half),
        .i_literal_word (i_literal_word),
        .o_desc         (front_desc)
    );

    tpcr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (start && !q_full),
        .i_push_desc (front_desc),
        .i_pop       (q_pop),
        .o_head      (head_desc),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    tpcr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head_desc),
        .i_empty           (q_empty),
        .o_pop             (q_pop),
        .o_strobe          (o_strobe),
        .o_out_half        (o_out_half),
        .o_last_of_run     (o_last_of_run),
        .o_consumed_halves (o_consumed_halves),
        .o_class_code      (o_class_code)
    );

    assign busy = q_full;

endmodule
